/* rtl/multi_queue_linked_fifo_top_macros.svh */
// assertion macros for the linked-list queue block
`ifndef MULTI_QUEUE_LINKED_FIFO_TOP_MACROS_SVH
`define MULTI_QUEUE_LINKED_FIFO_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define MQLF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("queue block check failed");

// next-cycle implication, checked outside reset
`define MQLF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("queue block check failed");

`endif

/* rtl/mqlf_pkg.sv */
// shared types and codes for the linked-list queue block
`default_nettype none
package mqlf_pkg;

  // operation codes
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // field widths
  localparam int ID_W    = 32;
  localparam int GRADE_W = 16;
  localparam int QSEL_W  = 2;
  localparam int REC_W   = ID_W + GRADE_W;

  // controller to datapath commands
  typedef struct packed {
    logic accept;  // latch item, issue memory reads
    logic exec;    // apply update, load result register
    logic clear;   // write one link entry of the clearing pass
  } mqlf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_done;  // last link entry is being written
    logic out_busy;    // result register holds an untaken transfer
  } mqlf_status_t;

endpackage
`default_nettype wire

/* rtl/multi_queue_linked_fifo_top.sv */
// Several FIFO queues sharing one linked entry pool with a free list.
// Each item passes an accept step (link and record memory read), then an execute step.
// No new item is taken until the last has executed; the link memory read is registered.
// Execute loads a result into an output register and waits while it holds an untaken result.
// After reset a clearing pass chains all POOL_DEPTH link entries; no items are taken then.
`default_nettype none
`include "multi_queue_linked_fifo_top_macros.svh"
module multi_queue_linked_fifo_top
  import mqlf_pkg::*;
#(
  parameter int NUM_QUEUES = 3,
  parameter int POOL_DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       operation,
  input  wire logic [QSEL_W-1:0]          queue_index,
  input  wire logic [ID_W-1:0]            record_id,
  input  wire logic signed [GRADE_W-1:0]  record_grade,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [ID_W-1:0]                 out_id,
  output logic signed [GRADE_W-1:0]       out_grade,
  output logic                            was_empty,
  output logic                            was_full
);

  mqlf_cmd_t    cmd;
  mqlf_status_t status;

  // control
  mqlf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // pool, pointers and result
  mqlf_datapath #(
    .NUM_QUEUES (NUM_QUEUES),
    .POOL_DEPTH (POOL_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .operation    (operation),
    .queue_index  (queue_index),
    .record_id    (record_id),
    .record_grade (record_grade),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_id       (out_id),
    .out_grade    (out_grade),
    .was_empty    (was_empty),
    .was_full     (was_full)
  );

  // checks
  `MQLF_ASSERT_NOW(a_cmd_exclusive, 1'b1, $onehot0({cmd.accept, cmd.exec, cmd.clear}))
  `MQLF_ASSERT_NEXT(a_busy_after_accept, cmd.accept, in_stall && !cmd.accept)
  `MQLF_ASSERT_NOW(a_flags_exclusive, out_valid, !(was_empty && was_full))
  `MQLF_ASSERT_NOW(a_flag_zero_data, out_valid && (was_empty || was_full),
                   out_id == '0 && out_grade == '0)

endmodule
`default_nettype wire

/* rtl/mqlf_ctrl.sv */
// controller state machine: link clearing pass, accept and execute steps
`default_nettype none
module mqlf_ctrl
  import mqlf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire mqlf_status_t status,
  output mqlf_cmd_t         cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // command decode
  always_comb begin
    cmd.clear  = (state == ST_CLEAR);
    cmd.accept = (state == ST_IDLE) && in_valid;
    cmd.exec   = (state == ST_EXEC) && !status.out_busy;
    in_stall   = (state != ST_IDLE);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (status.clear_done) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_EXEC;
      ST_EXEC:  if (!status.out_busy) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/mqlf_datapath.sv */
// datapath: entry pool, link memory, queue pointers, free list and result register
`default_nettype none
module mqlf_datapath
  import mqlf_pkg::*;
#(
  parameter int NUM_QUEUES = 3,
  parameter int POOL_DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire mqlf_cmd_t                  cmd,
  output mqlf_status_t                    status,
  input  wire logic                       operation,
  input  wire logic [QSEL_W-1:0]          queue_index,
  input  wire logic [ID_W-1:0]            record_id,
  input  wire logic signed [GRADE_W-1:0]  record_grade,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [ID_W-1:0]                 out_id,
  output logic signed [GRADE_W-1:0]       out_grade,
  output logic                            was_empty,
  output logic                            was_full
);

  localparam int PW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  // pool memories
  logic [PW-1:0]    link_mem [POOL_DEPTH];
  logic [REC_W-1:0] rec_mem  [POOL_DEPTH];
  logic [PW-1:0]    link_rd;
  logic [REC_W-1:0] rec_rd;

  // queue and free list state
  logic [PW-1:0]         head [NUM_QUEUES];
  logic [PW-1:0]         tail [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] nonempty;
  logic [PW-1:0]         free_head;
  logic [CW-1:0]         free_count;
  logic [PW-1:0]         clr_addr;

  // latched item
  logic                op_reg;
  logic [QSEL_W-1:0]   q_reg;
  logic [ID_W-1:0]     id_reg;
  logic [GRADE_W-1:0]  grade_reg;

  logic [QW-1:0] in_q_idx;
  logic          in_q_ok;
  logic [PW-1:0] rd_addr;
  logic [QW-1:0] q_idx;
  logic          q_ok;
  logic          q_live;
  logic          pool_empty;
  logic          enq_ok;
  logic          deq_ok;
  logic          link_we;
  logic [PW-1:0] link_wa;
  logic [PW-1:0] link_wd;

  // read address chosen from the incoming item
  always_comb begin
    in_q_idx = QW'(queue_index);
    in_q_ok  = (32'(queue_index) < NUM_QUEUES);
    if (operation == OP_DEQUEUE && in_q_ok) begin
      rd_addr = head[in_q_idx];
    end else begin
      rd_addr = free_head;
    end
  end

  // decode of the latched item
  always_comb begin
    q_idx      = QW'(q_reg);
    q_ok       = (32'(q_reg) < NUM_QUEUES);
    q_live     = q_ok && nonempty[q_idx];
    pool_empty = (free_count == '0);
    enq_ok     = (op_reg == OP_ENQUEUE) && q_ok && !pool_empty;
    deq_ok     = (op_reg == OP_DEQUEUE) && q_live;
  end

  // single link write port: clearing pass, tail append or free list return
  always_comb begin
    link_we = 1'b0;
    link_wa = clr_addr;
    link_wd = (clr_addr == PW'(POOL_DEPTH - 1)) ? '0 : clr_addr + PW'(1);
    if (cmd.clear) begin
      link_we = 1'b1;
    end else if (cmd.exec && enq_ok && q_live) begin
      link_we = 1'b1;
      link_wa = tail[q_idx];
      link_wd = free_head;
    end else if (cmd.exec && deq_ok) begin
      link_we = 1'b1;
      link_wa = head[q_idx];
      link_wd = free_head;
    end
  end

  always_comb begin
    status.clear_done = cmd.clear && (clr_addr == PW'(POOL_DEPTH - 1));
    status.out_busy   = out_valid && out_stall;
  end

  // memories
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (cmd.exec && enq_ok) begin
      rec_mem[free_head] <= {id_reg, grade_reg};
    end
    if (cmd.accept) begin
      link_rd <= link_mem[rd_addr];
      rec_rd  <= rec_mem[rd_addr];
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_reg    <= operation;
      q_reg     <= queue_index;
      id_reg    <= record_id;
      grade_reg <= record_grade;
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear && !status.clear_done) begin
      clr_addr <= clr_addr + PW'(1);
    end
  end

  // queue pointers and free list
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_QUEUES; k++) begin
        head[k] <= '0;
        tail[k] <= '0;
      end
      nonempty   <= '0;
      free_head  <= '0;
      free_count <= CW'(POOL_DEPTH);
    end else if (cmd.exec) begin
      if (enq_ok) begin
        free_head  <= link_rd;
        free_count <= free_count - CW'(1);
        if (!q_live) begin
          head[q_idx] <= free_head;
        end
        tail[q_idx]     <= free_head;
        nonempty[q_idx] <= 1'b1;
      end else if (deq_ok) begin
        if (head[q_idx] == tail[q_idx]) begin
          nonempty[q_idx] <= 1'b0;
        end else begin
          head[q_idx] <= link_rd;
        end
        free_head <= head[q_idx];
        if (free_count < CW'(POOL_DEPTH)) begin
          free_count <= free_count + CW'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_id    <= deq_ok ? rec_rd[REC_W-1:GRADE_W] : '0;
      out_grade <= deq_ok ? rec_rd[GRADE_W-1:0] : '0;
      was_empty <= (op_reg == OP_DEQUEUE) && !q_live;
      was_full  <= (op_reg == OP_ENQUEUE) && q_ok && pool_empty;
    end
  end

endmodule
`default_nettype wire

/* tb/multi_queue_linked_fifo_top_test.sv */
// self-checking testbench for the linked-list queue block with a shared entry pool
module multi_queue_linked_fifo_top_test;
  import mqlf_pkg::*;

  localparam int NUM_Q      = 3;
  localparam int POOL_SIZE  = 64;
  localparam int ITEM_GOAL  = 1250;
  localparam int CALM_START = 1100;
  localparam int LONG_HOLD  = 300;

  // one result as the block should produce it
  typedef struct {
    logic [ID_W-1:0]           id;
    logic signed [GRADE_W-1:0] grade;
    logic                      empty;
    logic                      full;
  } queue_result_t;

  // queues and free list kept in step with the block
  class queue_pool_model;
    logic [ID_W-1:0]           rec_id[POOL_SIZE];
    logic signed [GRADE_W-1:0] rec_grade[POOL_SIZE];
    int                        next_link[POOL_SIZE];
    int                        head[NUM_Q];
    int                        tail[NUM_Q];
    bit                        occupied[NUM_Q];
    int                        free_head;
    int                        free_count;
    queue_result_t             expected_results[$];
    int                        mismatch_count;

    function new();
      for (int k = 0; k < POOL_SIZE; k++) begin
        rec_id[k]    = '0;
        rec_grade[k] = '0;
        next_link[k] = (k + 1 < POOL_SIZE) ? k + 1 : 0;
      end
      for (int k = 0; k < NUM_Q; k++) begin
        head[k]     = 0;
        tail[k]     = 0;
        occupied[k] = 1'b0;
      end
      free_head      = 0;
      free_count     = POOL_SIZE;
      mismatch_count = 0;
    endfunction

    function int pending_count();
      return expected_results.size();
    endfunction

    // apply one accepted input transfer and queue up its result
    function void note_transfer(logic op, logic [QSEL_W-1:0] q, logic [ID_W-1:0] id,
                                logic signed [GRADE_W-1:0] grade);
      queue_result_t r;
      int            slot;
      r.id    = '0;
      r.grade = '0;
      r.empty = 1'b0;
      r.full  = 1'b0;
      if (op == OP_ENQUEUE) begin
        // out-of-range queue: enqueue silently ignored
        if (q < NUM_Q) begin
          if (free_count == 0) begin
            r.full = 1'b1;
          end else begin
            slot            = free_head;
            free_head       = next_link[slot];
            free_count--;
            rec_id[slot]    = id;
            rec_grade[slot] = grade;
            if (occupied[q]) next_link[tail[q]] = slot;
            else head[q] = slot;
            tail[q]     = slot;
            occupied[q] = 1'b1;
          end
        end
      end else if (q >= NUM_Q || !occupied[q]) begin
        r.empty = 1'b1;
      end else begin
        slot    = head[q];
        r.id    = rec_id[slot];
        r.grade = rec_grade[slot];
        if (slot == tail[q]) occupied[q] = 1'b0;
        else head[q] = next_link[slot];
        // freed entry goes back to the front of the free list
        next_link[slot] = free_head;
        free_head       = slot;
        if (free_count < POOL_SIZE) free_count++;
      end
      expected_results.push_back(r);
    endfunction

    // compare one output transfer with the oldest expectation
    function void check_result(logic [ID_W-1:0] id, logic signed [GRADE_W-1:0] grade,
                               logic empty, logic full);
      queue_result_t r;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result id %h grade %h empty %b full %b",
                 $time, id, grade, empty, full);
        mismatch_count++;
        return;
      end
      r = expected_results.pop_front();
      if (id !== r.id) begin
        $display("%0t: out_id expected %h actual %h", $time, r.id, id);
        mismatch_count++;
      end
      if (grade !== r.grade) begin
        $display("%0t: out_grade expected %h actual %h", $time, r.grade, grade);
        mismatch_count++;
      end
      if (empty !== r.empty) begin
        $display("%0t: was_empty expected %b actual %b", $time, r.empty, empty);
        mismatch_count++;
      end
      if (full !== r.full) begin
        $display("%0t: was_full expected %b actual %b", $time, r.full, full);
        mismatch_count++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic                      operation;
  logic [QSEL_W-1:0]         queue_index;
  logic [ID_W-1:0]           record_id;
  logic signed [GRADE_W-1:0] record_grade;
  logic                      out_valid;
  logic                      out_stall;
  logic [ID_W-1:0]           out_id;
  logic signed [GRADE_W-1:0] out_grade;
  logic                      was_empty;
  logic                      was_full;

  queue_pool_model pool = new();
  int              items_sent;
  bit              calm;
  bit              hold_request;

  multi_queue_linked_fifo_top #(
    .NUM_QUEUES(NUM_Q),
    .POOL_DEPTH(POOL_SIZE)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .queue_index(queue_index),
    .record_id(record_id),
    .record_grade(record_grade),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_id(out_id),
    .out_grade(out_grade),
    .was_empty(was_empty),
    .was_full(was_full)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

  // observe both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        pool.note_transfer(operation, queue_index, record_id, record_grade);
      if (out_valid && !out_stall)
        pool.check_result(out_id, out_grade, was_empty, was_full);
    end
  end

  // result side: random stall bursts, one long hold on request
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall    = 1'b0;
        hold_request = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        burst     = $urandom_range(1, 16);
        out_stall = 1'b1;
        repeat (burst) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // offer one item and hold it until the transfer happens
  task automatic send_item(input logic op, input logic [QSEL_W-1:0] q,
                           input logic [ID_W-1:0] id, input logic [GRADE_W-1:0] grade);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap      = $urandom_range(1, 16);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation    = op;
    queue_index  = q;
    record_id    = id;
    record_grade = grade;
    in_valid     = 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  // wait at the falling edge until every result has come back
  task automatic drain_results();
    in_valid = 1'b0;
    while (pool.pending_count() != 0) @(negedge clk);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [GRADE_W-1:0] pick_grade();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      default: return GRADE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [QSEL_W-1:0] pick_queue();
    if ($urandom_range(0, 19) == 0) return 2'd3;
    return QSEL_W'($urandom_range(0, NUM_Q - 1));
  endfunction

  // stimulus
  initial begin
    int segment;
    int seg_len;
    int enq_weight;
    rst          = 1'b1;
    in_valid     = 1'b0;
    operation    = OP_ENQUEUE;
    queue_index  = '0;
    record_id    = '0;
    record_grade = '0;
    items_sent   = 0;
    calm         = 1'b0;
    hold_request = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty queues, out-of-range queue, field extremes, FIFO order
    send_item(OP_DEQUEUE, 2'd0, 32'h0, 16'h0);
    send_item(OP_DEQUEUE, 2'd1, 32'h0, 16'h0);
    send_item(OP_DEQUEUE, 2'd2, 32'h0, 16'h0);
    send_item(OP_DEQUEUE, 2'd3, 32'hffffffff, 16'hffff);
    send_item(OP_ENQUEUE, 2'd3, 32'hffffffff, 16'h8000);
    send_item(OP_ENQUEUE, 2'd0, 32'h00000000, 16'h8000);
    send_item(OP_ENQUEUE, 2'd0, 32'hffffffff, 16'h7fff);
    send_item(OP_ENQUEUE, 2'd1, 32'h12345678, 16'hffff);
    send_item(OP_ENQUEUE, 2'd2, 32'ha5a5a5a5, 16'h5a5a);
    send_item(OP_DEQUEUE, 2'd3, 32'h0, 16'h0);
    send_item(OP_DEQUEUE, 2'd0, 32'h0, 16'h0);
    send_item(OP_DEQUEUE, 2'd0, 32'h0, 16'h0);
    send_item(OP_DEQUEUE, 2'd0, 32'h0, 16'h0);
    send_item(OP_DEQUEUE, 2'd1, 32'h0, 16'h0);
    send_item(OP_ENQUEUE, 2'd2, 32'h5a5a5a5a, 16'h0000);
    send_item(OP_DEQUEUE, 2'd2, 32'h0, 16'h0);
    send_item(OP_DEQUEUE, 2'd2, 32'h0, 16'h0);
    send_item(OP_DEQUEUE, 2'd2, 32'h0, 16'h0);

    // random segments: fill, drain or balanced traffic
    segment = 0;
    while (items_sent < ITEM_GOAL) begin
      case ($urandom_range(0, 2))
        0:       enq_weight = 85;
        1:       enq_weight = 15;
        default: enq_weight = 50;
      endcase
      seg_len = $urandom_range(40, 140);
      if (segment == 3) begin
        // long result hold while items keep coming
        enq_weight   = 85;
        hold_request = 1'b1;
      end
      if (segment == 6) drain_results();
      for (int k = 0; k < seg_len && items_sent < ITEM_GOAL; k++) begin
        if (items_sent >= CALM_START) calm = 1'b1;
        if ($urandom_range(1, 100) <= enq_weight)
          send_item(OP_ENQUEUE, pick_queue(), pick_id(), pick_grade());
        else
          send_item(OP_DEQUEUE, pick_queue(), pick_id(), pick_grade());
      end
      segment++;
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (pool.mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/mqlf_pkg.sv
rtl/mqlf_ctrl.sv
rtl/mqlf_datapath.sv
rtl/multi_queue_linked_fifo_top.sv
tb/multi_queue_linked_fifo_top_test.sv
